// ===== hdl/audio_silence_gate_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the audio silence gate.
// Each macro samples on clk and is disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef AUDIO_SILENCE_GATE_MACROS_SVH
`define AUDIO_SILENCE_GATE_MACROS_SVH

// A condition implies a property in the same cycle.
`define ASG_ASSERT_IMP(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

// A condition implies a property in the following cycle.
`define ASG_ASSERT_NXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

// ===== hdl/asg_pkg.sv =====
// ---------------------------------------------------------------------------
// asg_pkg
// Shared widths, reset values, register indexes and control types of the
// audio silence gate.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package asg_pkg;

	// Field widths.
	localparam int SAMPLE_W   = 16;
	localparam int THR_W      = 15;
	localparam int HOLD_W     = 16;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 1;

	// Default window length in samples.
	localparam int WINDOW_DEF = 64;

	// Register reset values (threshold is 0.15 in Q1.15, rounded down).
	localparam logic [THR_W-1:0]  THR_RESET  = 15'd4915;
	localparam logic [HOLD_W-1:0] HOLD_RESET = 16'd0;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD      = 1'b1;

	// Controls from the sequencer to the statistics unit.
	typedef struct packed {
		logic clear;
		logic acc;
		logic div_load;
		logic div_step;
	} stat_ctrl_t;

endpackage

// ===== hdl/asg_cell.sv =====
// ---------------------------------------------------------------------------
// asg_cell
// One window cell: holds one sample and takes its neighbor's sample on shift.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module asg_cell (
	input  logic                          clk,
	input  logic                          shift,
	input  logic [asg_pkg::SAMPLE_W-1:0]  nbr,
	output logic [asg_pkg::SAMPLE_W-1:0]  q
);

	logic [asg_pkg::SAMPLE_W-1:0] val_q;

	// Load the neighbor's sample whenever the row moves.
	always_ff @(posedge clk) begin
		if (shift) begin
			val_q <= nbr;
		end
	end

	assign q = val_q;

endmodule

// ===== hdl/asg_stat.sv =====
// ---------------------------------------------------------------------------
// asg_stat
// Window statistics: running sum, maximum and minimum over the samples that
// pass the head cell, then the floor mean and the range.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module asg_stat #(
	parameter int WINDOW = asg_pkg::WINDOW_DEF
) (
	input  logic                          clk,
	input  asg_pkg::stat_ctrl_t           ctrl,
	input  logic [asg_pkg::SAMPLE_W-1:0]  head,
	output logic [asg_pkg::SAMPLE_W-1:0]  mean,
	output logic [asg_pkg::SAMPLE_W:0]    range_full
);

	localparam int WIN_BITS = $clog2(WINDOW);
	localparam int SUM_W    = asg_pkg::SAMPLE_W + 1 + WIN_BITS;
	localparam bit IS_POW2  = (WINDOW & (WINDOW - 1)) == 0;

	logic signed [SUM_W-1:0]              sum_q;
	logic signed [asg_pkg::SAMPLE_W-1:0]  max_q;
	logic signed [asg_pkg::SAMPLE_W-1:0]  min_q;
	logic signed [asg_pkg::SAMPLE_W-1:0]  head_s;
	logic signed [SUM_W-1:0]              head_ext;

	assign head_s   = $signed(head);
	assign head_ext = {{(SUM_W - asg_pkg::SAMPLE_W){head[asg_pkg::SAMPLE_W-1]}}, head};

	// Accumulate one sample per cycle of the walk.
	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			sum_q <= '0;
			max_q <= {1'b1, {(asg_pkg::SAMPLE_W - 1){1'b0}}};
			min_q <= {1'b0, {(asg_pkg::SAMPLE_W - 1){1'b1}}};
		end else if (ctrl.acc) begin
			sum_q <= sum_q + head_ext;
			if (head_s > max_q) begin
				max_q <= head_s;
			end
			if (head_s < min_q) begin
				min_q <= head_s;
			end
		end
	end

	// Range is never negative once a sample has been seen.
	assign range_full = {max_q[asg_pkg::SAMPLE_W-1], max_q}
		- {min_q[asg_pkg::SAMPLE_W-1], min_q};

	generate
		if (IS_POW2) begin : g_shift
			logic signed [SUM_W-1:0] shifted;

			// Floor mean is an arithmetic shift.
			assign shifted = sum_q >>> WIN_BITS;
			assign mean    = shifted[asg_pkg::SAMPLE_W-1:0];
		end else begin : g_div
			localparam int DIV_SHIFT = SUM_W + WIN_BITS;
			localparam int PROD_W    = 2 * SUM_W + 2;
			localparam logic [63:0] RECIP_FULL =
				((64'd1 << DIV_SHIFT) + 64'(WINDOW - 1)) / 64'(WINDOW);
			localparam logic [SUM_W+1:0] RECIP = RECIP_FULL[SUM_W+1:0];

			logic [SUM_W-1:0]              mag_q;
			logic                          neg_q;
			logic [PROD_W-1:0]             prod_q;
			logic [asg_pkg::SAMPLE_W-1:0]  quo;

			// Divide the magnitude by multiplying with the rounded-up reciprocal.
			// A negative sum is biased by WINDOW-1 so its quotient rounds up,
			// which after negation rounds toward minus infinity.
			always_ff @(posedge clk) begin
				if (ctrl.div_load) begin
					neg_q <= sum_q[SUM_W-1];
					mag_q <= sum_q[SUM_W-1] ? SUM_W'(-sum_q) + SUM_W'(WINDOW - 1)
						: SUM_W'(sum_q);
				end else if (ctrl.div_step) begin
					prod_q <= PROD_W'(mag_q) * PROD_W'(RECIP);
				end
			end

			assign quo  = prod_q[DIV_SHIFT +: asg_pkg::SAMPLE_W];
			assign mean = neg_q ? -quo : quo;
		end
	endgenerate

endmodule

// ===== hdl/audio_silence_gate.sv =====
// ---------------------------------------------------------------------------
// audio_silence_gate
// Noise gate with hold over a sliding window of signed Q1.15 samples.
// ---------------------------------------------------------------------------
// One result comes out per request. The window lives in a row of WINDOW cells
// that shift the new sample in; after reset the first WINDOW+1 requests only
// fill the row, each going from accept straight to the result. For every later
// request the row rotates once through its head cell while the statistics
// unit accumulates sum, maximum and minimum, one sample a cycle, and the
// result is then written. For a WINDOW that is not a power of two the floor
// mean is found by a reciprocal multiplication before the result is written.
// The result register is written only when the downstream side has taken the
// previous one, and the next request is taken the cycle after that.
// No clearing pass is needed after reset.
`timescale 1ns / 1ps

`include "audio_silence_gate_macros.svh"

module audio_silence_gate #(
	parameter int WINDOW = asg_pkg::WINDOW_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Sample requests.
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [asg_pkg::SAMPLE_W-1:0]    sample,
	// Results.
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            silent,
	output logic [asg_pkg::SAMPLE_W-1:0]    window_mean,
	output logic [asg_pkg::SAMPLE_W-1:0]    window_range,
	output logic                            warmed_up,
	// Configuration writes.
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [asg_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [asg_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int WIN_BITS = $clog2(WINDOW);
	localparam int SUM_W    = asg_pkg::SAMPLE_W + 1 + WIN_BITS;
	localparam bit IS_POW2  = (WINDOW & (WINDOW - 1)) == 0;
	localparam int CNT_W    = $clog2(WINDOW + SUM_W + 1);
	localparam int FILL_W   = $clog2(WINDOW + 1);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_WALK = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	state_t                          state_q;
	logic [CNT_W-1:0]                cnt_q;
	logic [FILL_W-1:0]               fill_q;
	logic                            started_q;
	logic                            silent_q;
	logic [asg_pkg::HOLD_W-1:0]      hold_q;
	logic [asg_pkg::SAMPLE_W-1:0]    mean_q;
	logic [asg_pkg::SAMPLE_W-1:0]    range_q;
	logic                            out_valid_q;
	logic                            out_warm_q;
	logic [asg_pkg::THR_W-1:0]       thr_q;
	logic [asg_pkg::HOLD_W-1:0]      hold_max_q;

	logic                            accept;
	logic                            walking;
	logic                            out_free;
	logic                            emit;
	asg_pkg::stat_ctrl_t             ctrl;
	logic [asg_pkg::SAMPLE_W-1:0]    tail_in;
	logic [asg_pkg::SAMPLE_W-1:0]    tap [WINDOW];
	logic [asg_pkg::SAMPLE_W-1:0]    stat_mean;
	logic [asg_pkg::SAMPLE_W:0]      stat_range;
	logic                            quiet;

	// Handshake terms.
	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign walking   = (state_q == ST_WALK);
	assign out_free  = !out_valid_q || !out_stall;
	assign emit      = (state_q == ST_EMIT) && out_free;
	assign cfg_ready = 1'b1;

	// Configuration registers; other indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q      <= asg_pkg::THR_RESET;
			hold_max_q <= asg_pkg::HOLD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				asg_pkg::REG_THRESHOLD: thr_q      <= cfg_data[asg_pkg::THR_W-1:0];
				asg_pkg::REG_HOLD:      hold_max_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Window row: a new sample enters at the tail, and during the walk the head
	// wraps around to the tail so the row ends up in its original order.
	assign tail_in = walking ? tap[0] : sample;

	generate
		for (genvar i = 0; i < WINDOW; i++) begin : g_cell
			if (i == WINDOW - 1) begin : g_tail
				asg_cell u_cell (
					.clk   (clk),
					.shift (accept || walking),
					.nbr   (tail_in),
					.q     (tap[i])
				);
			end else begin : g_body
				asg_cell u_cell (
					.clk   (clk),
					.shift (accept || walking),
					.nbr   (tap[i+1]),
					.q     (tap[i])
				);
			end
		end
	endgenerate

	// Statistics unit controls.
	always_comb begin
		ctrl          = '0;
		ctrl.clear    = accept;
		ctrl.acc      = walking;
		ctrl.div_load = (state_q == ST_DIV) && (cnt_q == '0);
		ctrl.div_step = (state_q == ST_DIV) && (cnt_q != '0);
	end

	asg_stat #(
		.WINDOW (WINDOW)
	) u_stat (
		.clk        (clk),
		.ctrl       (ctrl),
		.head       (tap[0]),
		.mean       (stat_mean),
		.range_full (stat_range)
	);

	// Both mean and range must lie strictly below the threshold.
	assign quiet = ($signed(stat_mean) < $signed({1'b0, thr_q}))
		&& (stat_range < {2'b00, thr_q});

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (accept) begin
						state_q <= started_q ? ST_WALK : ST_EMIT;
					end
				end
				ST_WALK: begin
					if (cnt_q == CNT_W'(WINDOW - 1)) begin
						cnt_q   <= '0;
						state_q <= IS_POW2 ? ST_EMIT : ST_DIV;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DIV: begin
					// First load the magnitude, then multiply.
					if (cnt_q == CNT_W'(1)) begin
						cnt_q   <= '0;
						state_q <= ST_EMIT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Gate state, hold counter and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			started_q   <= 1'b0;
			silent_q    <= 1'b0;
			hold_q      <= '0;
			mean_q      <= '0;
			range_q     <= '0;
			out_valid_q <= 1'b0;
			out_warm_q  <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
			out_warm_q  <= started_q;
			if (!started_q) begin
				// Warm-up: count samples and repeat the held results.
				fill_q <= fill_q + 1'b1;
				if (fill_q == FILL_W'(WINDOW)) begin
					started_q <= 1'b1;
				end
			end else begin
				mean_q  <= stat_mean;
				range_q <= stat_range[asg_pkg::SAMPLE_W-1:0];
				if (!silent_q && quiet) begin
					// Sound to silence: hold off while the counter is below limit.
					if (hold_q < hold_max_q) begin
						hold_q   <= hold_q + 1'b1;
						silent_q <= 1'b0;
					end else begin
						hold_q   <= '0;
						silent_q <= 1'b1;
					end
				end else begin
					silent_q <= quiet;
				end
			end
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign silent       = silent_q;
	assign window_mean  = mean_q;
	assign window_range = range_q;
	assign warmed_up    = out_warm_q;

	// A warmed-up result can only follow the end of warm-up.
	`ASG_ASSERT_IMP(a_warm_after_start, out_valid_q && out_warm_q, started_q, "warm result before start")
	// Warm-up results never report silence.
	`ASG_ASSERT_IMP(a_warmup_not_silent, out_valid_q && !out_warm_q, !silent_q, "silence during warm-up")
	// The walk ends after exactly one pass over the row.
	`ASG_ASSERT_NXT(a_walk_exit, (state_q == ST_WALK) && (cnt_q == CNT_W'(WINDOW - 1)), (state_q == ST_EMIT) || (state_q == ST_DIV), "walk did not end")

endmodule

// ===== test/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the audio silence gate. A directed table walks the
// warm-up, full-scale windows, the threshold edges and floor rounding of the
// mean. Randomized quiet, loud, constant and impulse segments follow under
// several threshold and hold settings. Random request gaps and output stalls
// are applied in most segments. Every result is checked against the model or its table row.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

	localparam int WIN          = asg_pkg::WINDOW_DEF;
	localparam int WIN_SHIFT    = $clog2(WIN);
	localparam int CLK_PERIOD   = 4;
	localparam int STUCK_LIMIT  = 1000;
	localparam int RANDOM_ITEMS = 720;
	localparam int NUM_PHASES   = 6;
	localparam int CALM_ITEMS   = 60;
	localparam int NUM_ROWS     = 19;

	typedef struct packed {
		logic                         silent;
		logic [asg_pkg::SAMPLE_W-1:0] mean;
		logic [asg_pkg::SAMPLE_W-1:0] range;
		logic                         warm;
	} gate_result_t;

	typedef struct packed {
		logic [asg_pkg::SAMPLE_W-1:0] smp;
		logic [7:0]                   reps;
		logic                         typed;
		gate_result_t                 res;
	} stim_row_t;

	// Each row repeats one sample; a typed result applies to the last repeat.
	localparam stim_row_t DIRECTED [NUM_ROWS] = '{
		// Warm-up: outputs hold their reset values.
		'{16'h7FFF, 8'd1,  1'b1, '{1'b0, 16'h0000, 16'h0000, 1'b0}},
		'{16'h8000, 8'd1,  1'b1, '{1'b0, 16'h0000, 16'h0000, 1'b0}},
		'{16'h0000, 8'd1,  1'b1, '{1'b0, 16'h0000, 16'h0000, 1'b0}},
		'{16'h0001, 8'd1,  1'b1, '{1'b0, 16'h0000, 16'h0000, 1'b0}},
		'{16'hFFFF, 8'd1,  1'b1, '{1'b0, 16'h0000, 16'h0000, 1'b0}},
		'{16'h8000, 8'd60, 1'b1, '{1'b0, 16'h0000, 16'h0000, 1'b0}},
		// Full negative window: negative mean counts as silence.
		'{16'h8000, 8'd64, 1'b1, '{1'b1, 16'h8000, 16'h0000, 1'b1}},
		// Widest possible range.
		'{16'h7FFF, 8'd1,  1'b0, '{1'b0, 16'h0000, 16'h0000, 1'b0}},
		'{16'h7FFF, 8'd63, 1'b1, '{1'b0, 16'h7FFF, 16'h0000, 1'b1}},
		'{16'h0000, 8'd64, 1'b1, '{1'b1, 16'h0000, 16'h0000, 1'b1}},
		// Mean just below and exactly at the reset threshold.
		'{16'h1332, 8'd64, 1'b1, '{1'b1, 16'd4914,  16'h0000, 1'b1}},
		'{16'h1333, 8'd64, 1'b1, '{1'b0, 16'd4915,  16'h0000, 1'b1}},
		'{16'hFFFF, 8'd64, 1'b1, '{1'b1, 16'hFFFF, 16'h0000, 1'b1}},
		// One zero among minus ones: the mean rounds down to -1.
		'{16'h0000, 8'd1,  1'b0, '{1'b0, 16'h0000, 16'h0000, 1'b0}},
		'{16'h0000, 8'd63, 1'b1, '{1'b1, 16'h0000, 16'h0000, 1'b1}},
		// Range just below and exactly at the threshold.
		'{16'h1332, 8'd1,  1'b0, '{1'b0, 16'h0000, 16'h0000, 1'b0}},
		'{16'h1333, 8'd1,  1'b0, '{1'b0, 16'h0000, 16'h0000, 1'b0}},
		'{16'h8000, 8'd1,  1'b0, '{1'b0, 16'h0000, 16'h0000, 1'b0}},
		'{16'h0000, 8'd64, 1'b1, '{1'b1, 16'h0000, 16'h0000, 1'b1}}
	};

	logic                           clk          = 1'b0;
	logic                           arst_n       = 1'b0;
	logic                           in_valid     = 1'b0;
	logic                           in_stall;
	logic [asg_pkg::SAMPLE_W-1:0]   sample       = '0;
	logic                           out_valid;
	logic                           out_stall    = 1'b0;
	logic                           silent;
	logic [asg_pkg::SAMPLE_W-1:0]   window_mean;
	logic [asg_pkg::SAMPLE_W-1:0]   window_range;
	logic                           warmed_up;
	logic                           cfg_valid    = 1'b0;
	logic                           cfg_ready;
	logic [asg_pkg::CFG_IDX_W-1:0]  cfg_index    = asg_pkg::REG_THRESHOLD;
	logic [asg_pkg::CFG_DATA_W-1:0] cfg_data     = '0;

	// Model state of the gate and its registers.
	logic signed [asg_pkg::SAMPLE_W-1:0] win_q [WIN];
	int unsigned                  fill_cnt         = 0;
	bit                           gate_open        = 1'b0;
	bit                           gate_silent      = 1'b0;
	bit                           gate_silent_prev = 1'b0;
	logic [asg_pkg::HOLD_W-1:0]   hold_cnt         = '0;
	logic [asg_pkg::SAMPLE_W-1:0] mean_q           = '0;
	logic [asg_pkg::SAMPLE_W-1:0] range_q          = '0;
	logic [asg_pkg::THR_W-1:0]    thr_q            = asg_pkg::THR_RESET;
	logic [asg_pkg::HOLD_W-1:0]   hold_lim         = asg_pkg::HOLD_RESET;

	gate_result_t expected_q [$];
	int           gap_pct      = 0;
	int           stall_left   = 0;
	int           stuck_cycles = 0;
	int           fail_cnt     = 0;
	int           samples_sent = 0;
	int           analyzed_cnt = 0;
	int           silent_cnt   = 0;
	int           settings_cnt = 0;

	audio_silence_gate #(
		.WINDOW(WIN)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.sample       (sample),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.silent       (silent),
		.window_mean  (window_mean),
		.window_range (window_range),
		.warmed_up    (warmed_up),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Shift one sample into the window and compute the gate decision.
	function automatic gate_result_t gate_predict(
			input logic signed [asg_pkg::SAMPLE_W-1:0] smp);
		gate_result_t res;
		int           i;
		int           sum;
		int           hi;
		int           lo;
		int           avg;
		int           spread;
		sum = 0;
		hi  = -32768;
		lo  = 32767;
		for (i = 0; i < WIN - 1; i++)
			win_q[i] = win_q[i + 1];
		win_q[WIN - 1] = smp;
		// While filling, the previous outputs are repeated.
		if (!gate_open) begin
			fill_cnt++;
			if (fill_cnt > WIN)
				gate_open = 1'b1;
			res = '{gate_silent, mean_q, range_q, 1'b0};
			return res;
		end
		gate_silent_prev = gate_silent;
		for (i = 0; i < WIN; i++) begin
			sum += win_q[i];
			if (win_q[i] > hi)
				hi = win_q[i];
			if (win_q[i] < lo)
				lo = win_q[i];
		end
		avg     = sum >>> WIN_SHIFT;
		spread  = hi - lo;
		mean_q  = avg[asg_pkg::SAMPLE_W-1:0];
		range_q = spread[asg_pkg::SAMPLE_W-1:0];
		gate_silent = (avg < int'(thr_q)) && (spread < int'(thr_q));
		// Sound-to-silence change: hold off until the counter reaches the limit.
		if (!gate_silent_prev && gate_silent) begin
			if (hold_cnt < hold_lim) begin
				hold_cnt++;
				gate_silent = 1'b0;
			end else begin
				hold_cnt = '0;
			end
		end
		res = '{gate_silent, mean_q, range_q, 1'b1};
		return res;
	endfunction

	// Send one sample request, with an optional gap ahead of it.
	task automatic push_sample(input logic [asg_pkg::SAMPLE_W-1:0] smp, input bit typed,
			input gate_result_t typed_res);
		gate_result_t pred;
		if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample   <= smp;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pred = gate_predict(smp);
		expected_q.push_back(typed ? typed_res : pred);
		samples_sent++;
	endtask

	// Write both registers in random order while the gate is idle.
	task automatic apply_settings(input logic [asg_pkg::CFG_DATA_W-1:0] thr_data,
			input logic [asg_pkg::CFG_DATA_W-1:0] hold_data);
		logic [asg_pkg::CFG_IDX_W-1:0] idx;
		bit                            hold_first;
		int                            k;
		hold_first = 1'($urandom_range(0, 1));
		for (k = 0; k < 2; k++) begin
			idx       = ((k == 0) ^ hold_first) ? asg_pkg::REG_THRESHOLD : asg_pkg::REG_HOLD;
			cfg_valid <= 1'b1;
			cfg_index <= idx;
			cfg_data  <= (idx == asg_pkg::REG_THRESHOLD) ? thr_data : hold_data;
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			if (idx == asg_pkg::REG_THRESHOLD)
				thr_q = thr_data[asg_pkg::THR_W-1:0];
			else
				hold_lim = hold_data;
		end
		cfg_valid <= 1'b0;
		settings_cnt++;
		repeat (2) @(posedge clk);
	endtask

	// Stop sending and wait until every expected result has come back.
	task automatic wait_drained(input int settle);
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	// Downstream stalls come in bursts of random length, started with probability gap_pct.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			out_stall  <= 1'b1;
			stall_left = stall_left - 1;
		end else if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
			out_stall  <= 1'b1;
			stall_left = $urandom_range(0, 5);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Compare each accepted result with the oldest expectation.
	always @(posedge clk) begin
		gate_result_t exp_res;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_q.size() == 0) begin
				$error("result with no request pending: silent=%0d mean=%0d range=%0d",
					silent, $signed(window_mean), window_range);
				fail_cnt++;
			end else begin
				exp_res = expected_q.pop_front();
				if (silent !== exp_res.silent) begin
					$error("silent: expected %0d, got %0d", exp_res.silent, silent);
					fail_cnt++;
				end
				if (window_mean !== exp_res.mean) begin
					$error("window_mean: expected %0d, got %0d",
						$signed(exp_res.mean), $signed(window_mean));
					fail_cnt++;
				end
				if (window_range !== exp_res.range) begin
					$error("window_range: expected %0d, got %0d", exp_res.range, window_range);
					fail_cnt++;
				end
				if (warmed_up !== exp_res.warm) begin
					$error("warmed_up: expected %0d, got %0d", exp_res.warm, warmed_up);
					fail_cnt++;
				end
				if (warmed_up === 1'b1)
					analyzed_cnt++;
				if (silent === 1'b1)
					silent_cnt++;
			end
		end
	end

	// Count cycles in which no request, result or register write moves.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
	end

	initial begin
		while (stuck_cycles < STUCK_LIMIT) @(posedge clk);
		$display("Timeout: no progress for %0d cycles", STUCK_LIMIT);
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		int                             r;
		int                             k;
		int                             phase;
		int                             left;
		int                             seg_len;
		int                             kind;
		int                             t;
		int                             amp;
		int                             center;
		int                             const_val;
		int                             val;
		logic [asg_pkg::CFG_DATA_W-1:0] thr_data;
		logic [asg_pkg::CFG_DATA_W-1:0] hold_data;

		for (k = 0; k < WIN; k++)
			win_q[k] = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table under the reset register values.
		gap_pct = 20;
		for (r = 0; r < NUM_ROWS; r++) begin
			for (k = 0; k < DIRECTED[r].reps; k++)
				push_sample(DIRECTED[r].smp, DIRECTED[r].typed && (k == DIRECTED[r].reps - 1),
					DIRECTED[r].res);
		end

		// Random segments, one register setting per phase.
		for (phase = 0; phase < NUM_PHASES; phase++) begin
			case (phase)
				0: begin
					// Threshold of zero: the gate never reports silence.
					thr_data  = 16'h8000;
					hold_data = 16'd0;
				end
				1: begin
					thr_data  = 16'hFFFF;
					hold_data = 16'hFFFF;
				end
				2: begin
					thr_data  = 16'd4915;
					hold_data = 16'd3;
				end
				3: begin
					thr_data  = 16'd300;
					hold_data = 16'd1;
				end
				default: begin
					thr_data  = 16'($urandom_range(0, 65535));
					hold_data = 16'($urandom_range(0, 12));
				end
			endcase
			// Let every pending result drain before touching the registers.
			wait_drained(4);
			apply_settings(thr_data, hold_data);
			left = RANDOM_ITEMS / NUM_PHASES;
			while (left > 0) begin
				seg_len = $urandom_range(1, 96);
				if (seg_len > left)
					seg_len = left;
				if (phase == NUM_PHASES - 1 && left <= CALM_ITEMS)
					gap_pct = 0;
				else
					gap_pct = ($urandom_range(0, 3) == 0) ? 0 : 25;
				kind      = $urandom_range(0, 9);
				t         = int'(thr_q);
				amp       = $urandom_range(0, t + 64);
				center    = int'($urandom_range(0, t + 64)) - (t + 64) / 2;
				const_val = int'($urandom_range(0, 65535)) - 32768;
				for (k = 0; k < seg_len; k++) begin
					case (kind)
						5, 6: val = int'($urandom_range(0, 65535)) - 32768;
						7: val = const_val;
						8: begin
							// Mostly zero with rare full-scale clicks.
							if ($urandom_range(0, 15) == 0)
								val = $urandom_range(0, 1) ? 32767 : -32768;
							else
								val = 0;
						end
						9: val = t - 2 + int'($urandom_range(0, 3));
						default: val = center + int'($urandom_range(0, amp)) - amp / 2;
					endcase
					if (val > 32767)
						val = 32767;
					if (val < -32768)
						val = -32768;
					push_sample(val[asg_pkg::SAMPLE_W-1:0], 1'b0, '0);
				end
				left -= seg_len;
			end
		end

		gap_pct = 0;
		wait_drained(WIN + 8);

		$display("Covered %0d samples: %0d analyzed windows, %0d reported silent.",
			samples_sent, analyzed_cnt, silent_cnt);
		$display("Register settings applied: %0d, including zero and full-scale thresholds.",
			settings_cnt);
		if (fail_cnt == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
